@@ rtl/uart_receiver_with_fifo_core_defines.svh @@
// assertion macros for the uart receiver with fifo
`ifndef UART_RECEIVER_WITH_FIFO_CORE_DEFINES_SVH
`define UART_RECEIVER_WITH_FIFO_CORE_DEFINES_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication, disabled while in reset
`define URXF_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error("urxf check failed");
// next-cycle implication, disabled while in reset
`define URXF_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error("urxf check failed");
`else
`define URXF_ASSERT_IMP(lbl, ante, cons)
`define URXF_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

@@ rtl/urxf_pkg.sv @@
// shared types and constants for the uart receiver with fifo
`timescale 1ns / 1ps
package urxf_pkg;

	// frame outcome codes
	typedef enum logic [2:0] {
		EV_NONE    = 3'd0,
		EV_STORED  = 3'd1,
		EV_PARITY  = 3'd2,
		EV_FRAMING = 3'd3,
		EV_DROPPED = 3'd4
	} event_t;

	// parity mode codes
	localparam logic [1:0] PAR_ODD  = 2'd1;
	localparam logic [1:0] PAR_EVEN = 2'd2;

	// configuration register indexes
	localparam logic [1:0] REG_BIT_PERIOD  = 2'd0;
	localparam logic [1:0] REG_DATA_BITS   = 2'd1;
	localparam logic [1:0] REG_PARITY_MODE = 2'd2;

	// register reset values
	localparam logic [15:0] BIT_PERIOD_RST = 16'd434;
	localparam logic [3:0]  DATA_BITS_RST  = 4'd8;
	localparam logic [1:0]  PARITY_RST     = 2'd0;

	// data bit limits
	localparam logic [3:0] DATA_BITS_MIN = 4'd5;
	localparam logic [3:0] DATA_BITS_MAX = 4'd8;

	// frame shift register length
	localparam int SHIFT_W = 12;

	// result fields held in the output stage
	typedef struct packed {
		event_t      frame_event;
		logic        read_valid;
		logic [9:0]  fifo_count;
		logic [15:0] error_total;
	} result_t;

endpackage

@@ rtl/urxf_if.sv @@
// request channels of the uart receiver with fifo
`timescale 1ns / 1ps
interface urxf_in_if;
	logic valid;
	logic ready;
	logic rx_level;
	logic read_request;

	modport source (output valid, output rx_level, output read_request, input ready);
	modport sink (input valid, input rx_level, input read_request, output ready);
endinterface

interface urxf_out_if;
	logic       valid;
	logic       ready;
	logic [2:0] frame_event;
	logic       read_valid;
	logic [7:0] read_data;
	logic [9:0] fifo_count;
	logic [15:0] error_total;

	modport source (output valid, output frame_event, output read_valid, output read_data,
		output fifo_count, output error_total, input ready);
	modport sink (input valid, input frame_event, input read_valid, input read_data,
		input fifo_count, input error_total, output ready);
endinterface

@@ rtl/urxf_ram.sv @@
// generic single write port ram with registered read
`timescale 1ns / 1ps
module urxf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 512
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read port, data held when not enabled
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ rtl/uart_receiver_with_fifo_core.sv @@
// Uart receiver with byte fifo: one line sample per request, one result per request.
// Output: the result of a request appears in the cycle after acceptance (fifo ram read).
// Throughput: one request per cycle unless rx_out stalls; one ram read and one write port.
// Reset: arst_n low clears receiver, fifo pointers, count, error tally and loads
// register defaults; fifo contents are not cleared, unwritten entries are never read.
`timescale 1ns / 1ps
`include "uart_receiver_with_fifo_core_defines.svh"
module uart_receiver_with_fifo_core #(
	parameter int FIFO_DEPTH = 512
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data,
	urxf_in_if.sink     rx_in,
	urxf_out_if.source  rx_out
);

	localparam int IDX_W = $clog2(FIFO_DEPTH);
	localparam int CNT_W = $clog2(FIFO_DEPTH + 1);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(FIFO_DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(FIFO_DEPTH);

	// configuration registers
	logic [15:0] bit_period_q;
	logic [3:0]  data_bits_q;
	logic [1:0]  parity_mode_q;

	// receiver and fifo control state
	logic                     line_prev_q;
	logic                     receiving_q;
	logic [15:0]              countdown_q;
	logic [3:0]               bit_pos_q;
	logic [urxf_pkg::SHIFT_W-1:0] shift_q;
	logic                     ones_q;
	logic [IDX_W-1:0]         widx_q;
	logic [IDX_W-1:0]         ridx_q;
	logic [CNT_W-1:0]         held_q;
	logic [15:0]              tally_q;

	// output stage
	logic                valid_s1;
	urxf_pkg::result_t   res_s1;
	logic [7:0]          ram_rdata;

	logic accept;
	logic pop;
	logic [CNT_W-1:0] held_pop;
	logic [15:0] tally_pop;
	logic [3:0] nd;
	logic par_on;
	logic [3:0] stop_pos;
	logic sampling;
	logic [urxf_pkg::SHIFT_W-1:0] shift_new;
	logic ones_new;
	logic done;
	logic start_ok;
	logic stop_ok;
	logic pbit;
	logic parity_bad;
	logic full;
	logic [7:0] data_mask;
	logic [7:0] data_byte;
	urxf_pkg::event_t ev;
	logic store;
	logic [15:0] tally_next;
	logic [CNT_W-1:0] held_next;
	logic [31:0] held_ext;
	urxf_pkg::result_t res_next;

	// handshake
	assign accept       = rx_in.valid && rx_in.ready;
	assign rx_in.ready  = !valid_s1 || rx_out.ready;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_period_q  <= urxf_pkg::BIT_PERIOD_RST;
			data_bits_q   <= urxf_pkg::DATA_BITS_RST;
			parity_mode_q <= urxf_pkg::PARITY_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				urxf_pkg::REG_BIT_PERIOD:  bit_period_q  <= cfg_data;
				urxf_pkg::REG_DATA_BITS:   data_bits_q   <= cfg_data[3:0];
				urxf_pkg::REG_PARITY_MODE: parity_mode_q <= cfg_data[1:0];
				default: ;
			endcase
		end
	end

	// fifo pop, served from the state at the start of the cycle
	assign pop       = rx_in.read_request && (held_q != '0);
	assign held_pop  = held_q - CNT_W'(pop);
	assign tally_pop = (pop && held_pop == '0) ? 16'd0 : tally_q;

	// effective frame format
	always_comb begin
		if (data_bits_q < urxf_pkg::DATA_BITS_MIN) begin
			nd = urxf_pkg::DATA_BITS_MIN;
		end else if (data_bits_q > urxf_pkg::DATA_BITS_MAX) begin
			nd = urxf_pkg::DATA_BITS_MAX;
		end else begin
			nd = data_bits_q;
		end
	end
	assign par_on   = (parity_mode_q == urxf_pkg::PAR_ODD) ||
		(parity_mode_q == urxf_pkg::PAR_EVEN);
	assign stop_pos = nd + 4'd1 + {3'd0, par_on};

	// bit sampling
	assign sampling = receiving_q && (countdown_q <= 16'd1);
	always_comb begin
		for (int i = 0; i < urxf_pkg::SHIFT_W; i++) begin
			shift_new[i] = shift_q[i] || (rx_in.rx_level && bit_pos_q == 4'(i));
		end
	end
	always_comb begin
		if (bit_pos_q == 4'd0) begin
			ones_new = 1'b0;
		end else if (bit_pos_q <= nd && rx_in.rx_level) begin
			ones_new = !ones_q;
		end else begin
			ones_new = ones_q;
		end
	end
	assign done = sampling && (bit_pos_q >= stop_pos);

	// frame checks
	assign start_ok   = !shift_new[0];
	assign stop_ok    = shift_new[stop_pos];
	assign pbit       = shift_new[nd + 4'd1];
	assign parity_bad = par_on && ((ones_new ^ pbit) != (parity_mode_q == urxf_pkg::PAR_ODD));
	assign full       = held_pop >= FULL_CNT;
	assign data_mask  = 8'hFF >> (4'd8 - nd);
	assign data_byte  = shift_new[8:1] & data_mask;

	// frame outcome
	always_comb begin
		ev         = urxf_pkg::EV_NONE;
		store      = 1'b0;
		tally_next = tally_pop;
		if (done) begin
			if (!start_ok || !stop_ok) begin
				ev         = urxf_pkg::EV_FRAMING;
				tally_next = tally_pop + 16'd1;
			end else if (full) begin
				ev = urxf_pkg::EV_DROPPED;
			end else if (parity_bad) begin
				ev         = urxf_pkg::EV_PARITY;
				tally_next = tally_pop + 16'd1;
			end else begin
				ev    = urxf_pkg::EV_STORED;
				store = 1'b1;
			end
		end
	end
	assign held_next = held_pop + CNT_W'(store);
	assign held_ext  = 32'(held_next);

	// receiver and fifo state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_prev_q <= 1'b1;
			receiving_q <= 1'b0;
			countdown_q <= '0;
			bit_pos_q   <= '0;
			shift_q     <= '0;
			ones_q      <= 1'b0;
			widx_q      <= '0;
			ridx_q      <= '0;
			held_q      <= '0;
			tally_q     <= '0;
		end else if (accept) begin
			line_prev_q <= rx_in.rx_level;
			held_q      <= held_next;
			tally_q     <= tally_next;
			if (pop) begin
				ridx_q <= (ridx_q == LAST_IDX) ? '0 : ridx_q + IDX_W'(1);
			end
			if (store) begin
				widx_q <= (widx_q == LAST_IDX) ? '0 : widx_q + IDX_W'(1);
			end
			if (!receiving_q) begin
				if (line_prev_q && !rx_in.rx_level) begin
					receiving_q <= 1'b1;
					countdown_q <= bit_period_q >> 1;
					bit_pos_q   <= '0;
					shift_q     <= '0;
					ones_q      <= 1'b0;
				end
			end else if (!sampling) begin
				countdown_q <= countdown_q - 16'd1;
			end else begin
				countdown_q <= bit_period_q;
				shift_q     <= shift_new;
				ones_q      <= ones_new;
				if (done) begin
					receiving_q <= 1'b0;
					bit_pos_q   <= '0;
				end else begin
					bit_pos_q <= bit_pos_q + 4'd1;
				end
			end
		end
	end

	// fifo storage
	urxf_ram #(
		.WIDTH (8),
		.DEPTH (FIFO_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (accept && store),
		.waddr (widx_q),
		.wdata (data_byte),
		.re    (accept && pop),
		.raddr (ridx_q),
		.rdata (ram_rdata)
	);

	// result of this request
	always_comb begin
		res_next.frame_event = ev;
		res_next.read_valid  = pop;
		res_next.fifo_count  = held_ext[9:0];
		res_next.error_total = tally_next;
	end

	// output stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx_in.ready) begin
			valid_s1 <= rx_in.valid;
		end
	end
	always_ff @(posedge clk) begin
		if (accept) begin
			res_s1 <= res_next;
		end
	end

	assign rx_out.valid       = valid_s1;
	assign rx_out.frame_event = res_s1.frame_event;
	assign rx_out.read_valid  = res_s1.read_valid;
	assign rx_out.read_data   = res_s1.read_valid ? ram_rdata : 8'd0;
	assign rx_out.fifo_count  = res_s1.fifo_count;
	assign rx_out.error_total = res_s1.error_total;

	// checks
	`URXF_ASSERT_IMP(a_held_bound, 1'b1, held_q <= FULL_CNT)
	`URXF_ASSERT_IMP(a_idle_pos, !receiving_q, bit_pos_q == 4'd0)
	`URXF_ASSERT_NXT(a_pop_result, accept && pop, valid_s1 && res_s1.read_valid)
	`URXF_ASSERT_NXT(a_store_count, accept && store && !pop,
		held_q == $past(held_q) + CNT_W'(1))

endmodule
